// ----- hdl/interval_timer_three_channel_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Interval timer assertion macros
// Shared concurrent assertion shorthands for the timer RTL.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TIMER_THREE_CHANNEL_UNIT_MACROS_SVH
`define INTERVAL_TIMER_THREE_CHANNEL_UNIT_MACROS_SVH

// Plain property checked on every rising edge outside reset
`define ITMR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication checked outside reset
`define ITMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/itmr_pkg.sv -----
// ----------------------------------------------------------------------------
// Interval timer package
// Channel count, request and command codes, and the queued command word.
// ----------------------------------------------------------------------------
package itmr_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int CH_W         = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    typedef enum logic [1:0] {
        REQ_CTRL  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_LATCH = 3'd1,
        OP_MODE  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_TICK  = 3'd5
    } t_op;

    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LOW   = 2'd1;
    localparam logic [1:0] ACC_HIGH  = 2'd2;
    localparam logic [1:0] ACC_LOHI  = 2'd3;

    localparam logic [2:0] MODE_TERMINAL = 3'd0;
    localparam logic [2:0] MODE_RATE     = 3'd2;
    localparam logic [2:0] MODE_SQUARE   = 3'd3;

    typedef struct packed {
        t_op              op;
        logic [CH_W-1:0]  chan;
        logic [7:0]       data;
    } t_cmd;

endpackage

// ----- hdl/itmr_front.sv -----
// ----------------------------------------------------------------------------
// Interval timer front end
// Accepts bus words, decodes them into timer commands and queues them.
// ----------------------------------------------------------------------------
module itmr_front
    import itmr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_req,
    input  logic [CH_W-1:0]  i_chan,
    input  logic [7:0]       i_data,
    output logic             o_q_valid,
    output t_cmd             o_q_cmd,
    input  logic             i_q_pop
);

    t_cmd                r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    t_cmd                dec_cmd;
    logic                push;
    logic                pop;

    // Classify the word; words for absent channels become no-ops
    always_comb begin
        dec_cmd.op   = OP_NOP;
        dec_cmd.chan = i_chan;
        dec_cmd.data = i_data;
        case (t_req'(i_req))
            REQ_CTRL: begin
                dec_cmd.chan = i_data[7:6];
                if ({1'b0, i_data[7:6]} < 3'(NUM_CHANNELS)) begin
                    dec_cmd.op = (i_data[5:4] == ACC_LATCH) ? OP_LATCH : OP_MODE;
                end
            end
            REQ_WRITE: begin
                if ({1'b0, i_chan} < 3'(NUM_CHANNELS)) begin
                    dec_cmd.op = OP_WRITE;
                end
            end
            REQ_READ: begin
                if ({1'b0, i_chan} < 3'(NUM_CHANNELS)) begin
                    dec_cmd.op = OP_READ;
                end
            end
            REQ_TICK: begin
                dec_cmd.op = OP_TICK;
            end
            default: begin
                dec_cmd.op = OP_NOP;
            end
        endcase
    end

    assign o_ready   = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/itmr_back.sv -----
// ----------------------------------------------------------------------------
// Interval timer back end
// Executes queued commands on the channel registers and holds the result.
// ----------------------------------------------------------------------------
`include "interval_timer_three_channel_unit_macros.svh"

module itmr_back
    import itmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_irq_en,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_irq,
    output logic        o_timer_out
);

    logic [2:0]   r_mode        [NUM_CHANNELS];
    logic [1:0]   r_access      [NUM_CHANNELS];
    logic         r_bcd         [NUM_CHANNELS];
    logic [15:0]  r_reload      [NUM_CHANNELS];
    logic [15:0]  r_live        [NUM_CHANNELS];
    logic         r_latch_vld   [NUM_CHANNELS];
    logic [15:0]  r_latched     [NUM_CHANNELS];
    logic         r_read_phase  [NUM_CHANNELS];
    logic         r_write_phase [NUM_CHANNELS];
    logic [7:0]   r_low_hold    [NUM_CHANNELS];
    logic         r_level;

    logic [2:0]   n_mode        [NUM_CHANNELS];
    logic [1:0]   n_access      [NUM_CHANNELS];
    logic         n_bcd         [NUM_CHANNELS];
    logic [15:0]  n_reload      [NUM_CHANNELS];
    logic [15:0]  n_live        [NUM_CHANNELS];
    logic         n_latch_vld   [NUM_CHANNELS];
    logic [15:0]  n_latched     [NUM_CHANNELS];
    logic         n_read_phase  [NUM_CHANNELS];
    logic         n_write_phase [NUM_CHANNELS];
    logic [7:0]   n_low_hold    [NUM_CHANNELS];
    logic         n_level;

    logic         r_out_valid;
    logic [7:0]   r_out_rd;
    logic         r_out_irq;
    logic         r_out_lvl;

    logic [CH_W-1:0] idx;
    logic [15:0]     cnt;
    logic [15:0]     dec;
    logic [7:0]      rd;
    logic            irq;
    logic            pop;
    logic [15:0]     live0;
    logic            tick_zero_reload;

    assign pop     = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = pop;
    assign idx     = i_q_cmd.chan;
    assign cnt     = r_latch_vld[idx] ? r_latched[idx] : r_live[idx];
    assign dec     = r_live[0] - 16'd1;
    assign live0   = r_live[0];
    assign tick_zero_reload = pop && (i_q_cmd.op == OP_TICK) && (r_reload[0] == 16'd0);

    always_comb begin
        n_mode        = r_mode;
        n_access      = r_access;
        n_bcd         = r_bcd;
        n_reload      = r_reload;
        n_live        = r_live;
        n_latch_vld   = r_latch_vld;
        n_latched     = r_latched;
        n_read_phase  = r_read_phase;
        n_write_phase = r_write_phase;
        n_low_hold    = r_low_hold;
        n_level       = r_level;
        rd            = 8'h00;
        irq           = 1'b0;
        case (i_q_cmd.op)
            OP_LATCH: begin
                n_latch_vld[idx] = 1'b1;
                n_latched[idx]   = r_live[idx];
            end
            OP_MODE: begin
                n_access[idx]      = i_q_cmd.data[5:4];
                n_mode[idx]        = i_q_cmd.data[3:1];
                n_bcd[idx]         = i_q_cmd.data[0];
                n_write_phase[idx] = 1'b0;
                n_read_phase[idx]  = 1'b0;
            end
            OP_WRITE: begin
                case (r_access[idx])
                    ACC_LOW: begin
                        n_reload[idx]      = {r_reload[idx][15:8], i_q_cmd.data};
                        n_live[idx]        = {r_reload[idx][15:8], i_q_cmd.data};
                        n_write_phase[idx] = 1'b0;
                    end
                    ACC_HIGH: begin
                        n_reload[idx]      = {i_q_cmd.data, r_reload[idx][7:0]};
                        n_live[idx]        = {i_q_cmd.data, r_reload[idx][7:0]};
                        n_write_phase[idx] = 1'b0;
                    end
                    ACC_LOHI: begin
                        if (!r_write_phase[idx]) begin
                            n_low_hold[idx]    = i_q_cmd.data;
                            n_write_phase[idx] = 1'b1;
                        end else begin
                            n_reload[idx]      = {i_q_cmd.data, r_low_hold[idx]};
                            n_live[idx]        = {i_q_cmd.data, r_low_hold[idx]};
                            n_write_phase[idx] = 1'b0;
                        end
                    end
                    default: begin
                        n_write_phase[idx] = r_write_phase[idx];
                    end
                endcase
            end
            OP_READ: begin
                case (r_access[idx])
                    ACC_LOW: begin
                        n_latch_vld[idx] = 1'b0;
                        rd               = cnt[7:0];
                    end
                    ACC_HIGH: begin
                        n_latch_vld[idx] = 1'b0;
                        rd               = cnt[15:8];
                    end
                    ACC_LOHI: begin
                        if (!r_read_phase[idx]) begin
                            n_read_phase[idx] = 1'b1;
                            rd                = cnt[7:0];
                        end else begin
                            n_read_phase[idx] = 1'b0;
                            n_latch_vld[idx]  = 1'b0;
                            rd                = cnt[15:8];
                        end
                    end
                    default: begin
                        rd = 8'h00;
                    end
                endcase
            end
            OP_TICK: begin
                // Only channel 0 counts; a zero reload stops it
                if (r_reload[0] != 16'd0) begin
                    if (dec != 16'd0) begin
                        n_live[0] = dec;
                    end else begin
                        n_live[0] = r_reload[0];
                        case (r_mode[0])
                            MODE_TERMINAL: begin
                                n_level = 1'b1;
                                irq     = 1'b1;
                            end
                            MODE_RATE: begin
                                irq = 1'b1;
                            end
                            MODE_SQUARE: begin
                                n_level = ~r_level;
                                irq     = ~r_level;
                            end
                            default: begin
                                irq = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                rd = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_mode[i]        <= MODE_SQUARE;
                r_access[i]      <= ACC_LOHI;
                r_bcd[i]         <= 1'b0;
                r_reload[i]      <= 16'd0;
                r_live[i]        <= 16'd0;
                r_latch_vld[i]   <= 1'b0;
                r_latched[i]     <= 16'd0;
                r_read_phase[i]  <= 1'b0;
                r_write_phase[i] <= 1'b0;
                r_low_hold[i]    <= 8'h00;
            end
            r_level <= 1'b1;
        end else if (pop) begin
            r_mode        <= n_mode;
            r_access      <= n_access;
            r_bcd         <= n_bcd;
            r_reload      <= n_reload;
            r_live        <= n_live;
            r_latch_vld   <= n_latch_vld;
            r_latched     <= n_latched;
            r_read_phase  <= n_read_phase;
            r_write_phase <= n_write_phase;
            r_low_hold    <= n_low_hold;
            r_level       <= n_level;
        end
    end

    // Output register: load on pop, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_rd  <= rd;
            r_out_irq <= irq && i_irq_en;
            r_out_lvl <= n_level;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_rd;
    assign o_irq       = r_out_irq;
    assign o_timer_out = r_out_lvl;

    `ITMR_ASSERT(a_irq_no_data, i_clk, i_rst_n, !(r_out_valid && r_out_irq) || (r_out_rd == 8'h00), "interrupt word carries read data")
    `ITMR_ASSERT_NEXT(a_zero_reload_hold, i_clk, i_rst_n, tick_zero_reload, $stable(live0), "channel 0 counted with zero reload")
    `ITMR_ASSERT_NEXT(a_zero_reload_quiet, i_clk, i_rst_n, tick_zero_reload, !r_out_irq, "interrupt raised with zero reload")

endmodule

// ----- hdl/interval_timer_three_channel_unit.sv -----
// Path: a word accepted on the slave side is written into the command queue, then executed
//   by the back end, whose result word is held in the output register for the master side.
// Throughput: one word per cycle unless the master side holds back result words and the queue fills.
// Reset (i_rst_n low at a rising edge): queue and output register empty, all channels
//   mode 3, access low/high, counts zero, channel 0 output high, interrupt reporting on.
// ----------------------------------------------------------------------------
// Three-channel interval timer
// Stream-side bus decode, two-word command queue and timer execute stage.
// ----------------------------------------------------------------------------
module interval_timer_three_channel_unit
    import itmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,    // irq_connected
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data
    input  logic [3:0]  s_axis_tuser,   // [1:0] req_type, [3:2] channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] irq_raised, [9] timer_out
);

    logic        r_irq_en;
    logic        q_valid;
    t_cmd        q_cmd;
    logic        q_pop;
    logic [7:0]  out_rd;
    logic        out_irq;
    logic        out_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_irq_en <= i_cfg_wdata;
        end
    end

    itmr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_req     (s_axis_tuser[1:0]),
        .i_chan    (s_axis_tuser[3:2]),
        .i_data    (s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    itmr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_irq_en    (r_irq_en),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_read_data (out_rd),
        .o_irq       (out_irq),
        .o_timer_out (out_lvl)
    );

    assign m_axis_tdata = {6'b0, out_lvl, out_irq, out_rd};

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval timer testbench
// Streams control writes, data writes, reads and ticks into the timer with
// random gaps on both sides, predicts every result word in-bench and checks
// them in order, over several interrupt-reporting settings.
// ----------------------------------------------------------------------------
module testbench;
    import itmr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 120;

    typedef struct {
        t_req       req;
        logic [1:0] chan;
        logic [7:0] data;
    } t_bus_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;     // [7:0] data
    logic [3:0]  s_axis_tuser = 4'd0;     // [1:0] req_type, [3:2] channel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [7:0] read_data, [8] irq_raised, [9] timer_out

    interval_timer_three_channel_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Timer shadow state
    logic        irq_enable;
    logic [2:0]  sh_mode     [NUM_CHANNELS];
    logic [1:0]  sh_access   [NUM_CHANNELS];
    logic        sh_bcd      [NUM_CHANNELS];
    logic [15:0] sh_reload   [NUM_CHANNELS];
    logic [15:0] sh_count    [NUM_CHANNELS];
    logic        sh_latched  [NUM_CHANNELS];
    logic [15:0] sh_latch    [NUM_CHANNELS];
    logic        sh_rd_phase [NUM_CHANNELS];
    logic        sh_wr_phase [NUM_CHANNELS];
    logic [7:0]  sh_low_hold [NUM_CHANNELS];
    logic        sh_out;

    t_bus_word   bus_words[$];
    logic [9:0]  expected_words[$];
    int          words_queued = 0;
    int          words_accepted = 0;
    int          results_seen = 0;
    int          errors = 0;
    int          cycle_count = 0;

    t_bus_word   next_word;
    logic [9:0]  predicted;
    logic [9:0]  want;
    logic        out_taken;
    logic        send_burst = 1'b0;
    logic        recv_burst = 1'b0;
    int          send_wait = 0;
    int          recv_wait = 0;
    int          hold_left = 0;
    int          recv_draw;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void timer_reset_shadow();
        irq_enable = 1'b1;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            sh_mode[i]     = MODE_SQUARE;
            sh_access[i]   = ACC_LOHI;
            sh_bcd[i]      = 1'b0;
            sh_reload[i]   = 16'd0;
            sh_count[i]    = 16'd0;
            sh_latched[i]  = 1'b0;
            sh_latch[i]    = 16'd0;
            sh_rd_phase[i] = 1'b0;
            sh_wr_phase[i] = 1'b0;
            sh_low_hold[i] = 8'd0;
        end
        sh_out = 1'b1;
    endfunction

    // Returns {timer_out, irq_raised, read_data}
    function automatic logic [9:0] timer_predict(t_req req, logic [1:0] ch, logic [7:0] d);
        logic [1:0]  sel;
        logic [7:0]  rd;
        logic        irq;
        logic [15:0] cnt;
        sel = d[7:6];
        rd  = 8'd0;
        irq = 1'b0;
        case (req)
            REQ_CTRL: begin
                if (sel < NUM_CHANNELS) begin
                    if (d[5:4] == ACC_LATCH) begin
                        sh_latched[sel] = 1'b1;
                        sh_latch[sel]   = sh_count[sel];
                    end else begin
                        sh_access[sel]   = d[5:4];
                        sh_mode[sel]     = d[3:1];
                        sh_bcd[sel]      = d[0];
                        sh_wr_phase[sel] = 1'b0;
                        sh_rd_phase[sel] = 1'b0;
                    end
                end
            end
            REQ_WRITE: begin
                if (ch < NUM_CHANNELS) begin
                    case (sh_access[ch])
                        ACC_LOW: begin
                            sh_reload[ch]   = {sh_reload[ch][15:8], d};
                            sh_count[ch]    = sh_reload[ch];
                            sh_wr_phase[ch] = 1'b0;
                        end
                        ACC_HIGH: begin
                            sh_reload[ch]   = {d, sh_reload[ch][7:0]};
                            sh_count[ch]    = sh_reload[ch];
                            sh_wr_phase[ch] = 1'b0;
                        end
                        ACC_LOHI: begin
                            if (!sh_wr_phase[ch]) begin
                                sh_low_hold[ch] = d;
                                sh_wr_phase[ch] = 1'b1;
                            end else begin
                                sh_reload[ch]   = {d, sh_low_hold[ch]};
                                sh_count[ch]    = sh_reload[ch];
                                sh_wr_phase[ch] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            REQ_READ: begin
                if (ch < NUM_CHANNELS) begin
                    cnt = sh_latched[ch] ? sh_latch[ch] : sh_count[ch];
                    case (sh_access[ch])
                        ACC_LOW: begin
                            sh_latched[ch] = 1'b0;
                            rd = cnt[7:0];
                        end
                        ACC_HIGH: begin
                            sh_latched[ch] = 1'b0;
                            rd = cnt[15:8];
                        end
                        ACC_LOHI: begin
                            if (!sh_rd_phase[ch]) begin
                                sh_rd_phase[ch] = 1'b1;
                                rd = cnt[7:0];
                            end else begin
                                sh_rd_phase[ch] = 1'b0;
                                sh_latched[ch]  = 1'b0;
                                rd = cnt[15:8];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                // Only channel 0 counts; a zero reload freezes it
                if (sh_reload[0] != 16'd0) begin
                    sh_count[0] = sh_count[0] - 16'd1;
                    if (sh_count[0] == 16'd0) begin
                        sh_count[0] = sh_reload[0];
                        case (sh_mode[0])
                            MODE_TERMINAL: begin
                                sh_out = 1'b1;
                                irq = 1'b1;
                            end
                            MODE_RATE: irq = 1'b1;
                            MODE_SQUARE: begin
                                sh_out = ~sh_out;
                                irq = sh_out;
                            end
                            default: ;
                        endcase
                        irq = irq & irq_enable;
                    end
                end
            end
        endcase
        return {sh_out, irq, rd};
    endfunction

    function automatic logic [7:0] mode_word(logic [1:0] sel, logic [1:0] acc,
                                             logic [2:0] mode, logic bcd);
        return {sel, acc, mode, bcd};
    endfunction

    task automatic push_word(t_req req, logic [1:0] ch, logic [7:0] d);
        t_bus_word w;
        w.req  = req;
        w.chan = ch;
        w.data = d;
        bus_words.push_back(w);
        words_queued++;
    endtask

    task automatic wait_idle();
        while (words_accepted != words_queued || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_irq_enable(logic v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        irq_enable = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly small reload values so channel 0 reaches zero often
    function automatic logic [7:0] count_byte();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 4));
    endfunction

    task automatic add_random_words(int n);
        int added;
        int pick;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // program channel 0 as low then high with a short count
                push_word(REQ_CTRL, 2'($urandom_range(0, 3)),
                          mode_word(2'd0, ACC_LOHI, 3'($urandom_range(0, 7)),
                                    1'($urandom_range(0, 1))));
                push_word(REQ_WRITE, 2'd0, 8'($urandom_range(1, 8)));
                push_word(REQ_WRITE, 2'd0, ($urandom_range(0, 7) == 0) ?
                          8'($urandom_range(0, 255)) : 8'd0);
                added += 3;
            end else if (pick < 45) begin
                push_word(REQ_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                added++;
            end else if (pick < 57) begin
                push_word(REQ_CTRL, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                added++;
            end else if (pick < 65) begin
                push_word(REQ_CTRL, 2'($urandom_range(0, 3)),
                          mode_word(2'($urandom_range(0, 3)), ACC_LATCH,
                                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
                added++;
            end else if (pick < 82) begin
                push_word(REQ_WRITE, 2'($urandom_range(0, 3)), count_byte());
                added++;
            end else begin
                push_word(REQ_READ, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                added++;
            end
        end
    endtask

    // Driver: present the next bus word after its drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted = timer_predict(t_req'(s_axis_tuser[1:0]), s_axis_tuser[3:2],
                                          s_axis_tdata);
                expected_words.push_back(predicted);
                words_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait != 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_wait = send_wait - 1;
                end else if (bus_words.size() != 0) begin
                    next_word = bus_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.data;
                    s_axis_tuser  <= {next_word.chan, next_word.req};
                    if ($urandom_range(0, 39) == 0)
                        send_burst = ~send_burst;
                    send_wait = send_burst ? 0 : $urandom_range(0, 17);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word and pace tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            out_taken = m_axis_tvalid && m_axis_tready;
            if (out_taken) begin
                results_seen++;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, actual %0h", $time,
                             m_axis_tdata[9:0]);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_axis_tdata[7:0] !== want[7:0]) begin
                        $display("%0t: read_data mismatch, expected %0h actual %0h",
                                 $time, want[7:0], m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[8] !== want[8]) begin
                        $display("%0t: irq_raised mismatch, expected %0h actual %0h",
                                 $time, want[8], m_axis_tdata[8]);
                        errors++;
                    end
                    if (m_axis_tdata[9] !== want[9]) begin
                        $display("%0t: timer_out mismatch, expected %0h actual %0h",
                                 $time, want[9], m_axis_tdata[9]);
                        errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (out_taken && (results_seen == 300 || results_seen == 1200)) begin
                // long hold so the block backs up and stalls its input
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (out_taken) begin
                if ($urandom_range(0, 39) == 0)
                    recv_burst = ~recv_burst;
                recv_draw = recv_burst ? 0 : $urandom_range(0, 17);
                recv_wait = recv_draw;
                m_axis_tready <= (recv_draw == 0);
            end else if (recv_wait != 0) begin
                recv_wait = recv_wait - 1;
                m_axis_tready <= (recv_wait == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        timer_reset_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_irq_enable(1'b1);

        push_word(REQ_TICK, 2'd2, 8'hFF);
        push_word(REQ_READ, 2'd0, 8'h00);
        push_word(REQ_READ, 2'd3, 8'h00);
        push_word(REQ_CTRL, 2'd0, mode_word(2'd3, ACC_HIGH, MODE_SQUARE, 1'b0));
        push_word(REQ_CTRL, 2'd0, mode_word(2'd0, ACC_LOHI, MODE_RATE, 1'b0));
        push_word(REQ_WRITE, 2'd0, 8'h02);
        push_word(REQ_WRITE, 2'd0, 8'h00);
        push_word(REQ_TICK, 2'd0, 8'h00);
        push_word(REQ_TICK, 2'd1, 8'hAA);
        push_word(REQ_CTRL, 2'd0, mode_word(2'd0, ACC_LATCH, 3'd0, 1'b0));
        push_word(REQ_TICK, 2'd3, 8'h55);
        // latch again while latched
        push_word(REQ_CTRL, 2'd0, mode_word(2'd0, ACC_LATCH, 3'd0, 1'b0));
        push_word(REQ_READ, 2'd0, 8'h00);
        push_word(REQ_READ, 2'd0, 8'h00);
        push_word(REQ_WRITE, 2'd3, 8'hFF);
        push_word(REQ_CTRL, 2'd0, mode_word(2'd1, ACC_LOW, 3'd7, 1'b1));
        push_word(REQ_WRITE, 2'd1, 8'hFF);
        push_word(REQ_READ, 2'd1, 8'h00);
        push_word(REQ_CTRL, 2'd0, mode_word(2'd2, ACC_HIGH, MODE_TERMINAL, 1'b0));
        push_word(REQ_WRITE, 2'd2, 8'h80);
        push_word(REQ_READ, 2'd2, 8'h00);
        push_word(REQ_CTRL, 2'd0, mode_word(2'd0, ACC_LOW, MODE_SQUARE, 1'b0));
        push_word(REQ_WRITE, 2'd0, 8'h01);
        push_word(REQ_TICK, 2'd0, 8'h00);
        push_word(REQ_TICK, 2'd0, 8'h00);

        write_irq_enable(1'b0);
        add_random_words(550);
        write_irq_enable(1'b1);
        add_random_words(550);
        write_irq_enable(1'b0);
        add_random_words(550);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
